### hw/rtl/dus_pkg.sv
// ----------------------------------------------------------------------------
// dus_pkg: shared types and constants for the double ULP stepper
// Holds the binary64 field constants and the payload structs that pass
// between the top level and the step datapath.
// ----------------------------------------------------------------------------
package dus_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned MagW  = WordW - 1;

	// magnitude of +/- infinity; anything above it is a NaN
	localparam logic [MagW-1:0] InfMag = 63'h7ff0_0000_0000_0000;

	typedef struct packed {
		logic [WordW-1:0] value_bits;
		logic [WordW-1:0] step_count;
		logic             mode;
	} item_t;

	typedef struct packed {
		logic [WordW-1:0] result_bits;
		logic             saturated;
	} result_t;

endpackage

### hw/rtl/dus_stream_if.sv
// ----------------------------------------------------------------------------
// dus_stream_if: valid/ready channels of the double ULP stepper
// One interface for the operand channel, one for the result channel.
// ----------------------------------------------------------------------------
interface dus_item_if;
	logic                     valid;
	logic                     ready;
	logic [dus_pkg::WordW-1:0] value_bits;
	logic [dus_pkg::WordW-1:0] step_count;
	logic                     mode;

	modport source (output valid, output value_bits, output step_count, output mode,
		input ready);
	modport sink (input valid, input value_bits, input step_count, input mode,
		output ready);
endinterface

interface dus_result_if;
	logic                     valid;
	logic                     ready;
	logic [dus_pkg::WordW-1:0] result_bits;
	logic                     saturated;

	modport source (output valid, output result_bits, output saturated, input ready);
	modport sink (input valid, input result_bits, input saturated, output ready);
endinterface

### hw/rtl/dus_step.sv
// ----------------------------------------------------------------------------
// dus_step: one-pass ULP step datapath
// Treats the binary64 pattern as sign-magnitude and moves it up by the
// count; downward moves run with the sign flipped on both sides.
// ----------------------------------------------------------------------------
module dus_step (
	input  dus_pkg::item_t   item,
	output dus_pkg::result_t res
);

	localparam int unsigned W = dus_pkg::WordW;
	localparam int unsigned M = dus_pkg::MagW;

	logic [M-1:0] mag;
	logic         neg;
	logic [W-1:0] cnt;
	logic [W-1:0] room;
	logic [W-1:0] sum;
	logic [W-1:0] rise;
	logic [M-1:0] diff;
	logic         is_nan;
	logic         cnt_zero;
	logic [W-1:0] up_bits;
	logic         up_sat;

	assign mag      = item.value_bits[M-1:0];
	assign neg      = item.value_bits[W-1] ^ item.mode;
	assign cnt      = item.step_count;
	assign is_nan   = mag > dus_pkg::InfMag;
	assign cnt_zero = cnt == '0;

	assign room = {1'b0, dus_pkg::InfMag - mag};
	assign sum  = {1'b0, mag} + cnt;
	assign rise = cnt - {1'b0, mag};
	assign diff = mag - cnt[M-1:0];

	always_comb begin
		up_sat  = 1'b0;
		up_bits = {1'b0, dus_pkg::InfMag};
		if (!neg) begin
			if (cnt < room) begin
				up_bits = sum;
			end else begin
				up_sat = 1'b1;
			end
		end else if ({1'b0, mag} >= cnt) begin
			up_bits = {1'b1, diff};
		end else if (rise < {1'b0, dus_pkg::InfMag}) begin
			// crossed zero into the positive values
			up_bits = rise;
		end else begin
			up_sat = 1'b1;
		end
	end

	always_comb begin
		if (is_nan || cnt_zero) begin
			res.result_bits = item.value_bits;
			res.saturated   = 1'b0;
		end else begin
			res.result_bits = up_bits ^ {item.mode, {M{1'b0}}};
			res.saturated   = up_sat;
		end
	end

endmodule

### hw/rtl/double_ulp_step.sv
// ----------------------------------------------------------------------------
// double_ulp_step: move a binary64 value by N representable doubles
// Registered operand stage, single-pass step logic, registered result stage.
// ----------------------------------------------------------------------------
// One operand transaction is accepted per clock while the operand side is
// ready; it moves through the operand register, a single pass of 64-bit
// add/subtract/compare logic and the result register. Backpressure on the
// result channel stalls the result stage, and the operand stage once full;
// the operand side stays ready whenever either stage has room.
// NaN inputs and a zero count return the input unchanged; moves that reach
// the infinity of the direction clamp there and set saturated.
module double_ulp_step (
	input  logic         clk,
	input  logic         arst_n,
	dus_item_if.sink     operand,
	dus_result_if.source result
);

	dus_pkg::item_t   item_s1;
	logic             valid_s1;
	dus_pkg::result_t res_comb;
	dus_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv_s2;
	logic             adv_s1;

	assign adv_s2        = !valid_s2 || result.ready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign operand.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= operand.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && operand.valid) begin
			item_s1.value_bits <= operand.value_bits;
			item_s1.step_count <= operand.step_count;
			item_s1.mode       <= operand.mode;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	dus_step u_step (
		.item (item_s1),
		.res  (res_comb)
	);

	assign result.valid       = valid_s2;
	assign result.result_bits = res_s2.result_bits;
	assign result.saturated   = res_s2.saturated;

endmodule

### hw/rtl/dus_checker.sv
// ----------------------------------------------------------------------------
// dus_checker: port-level checks for double_ulp_step
// Watches the operand and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module dus_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [dus_pkg::WordW-1:0] out_bits,
	input logic                      out_sat
);

	// a pending result transaction is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits) && $stable(out_sat))
		else $error("result transaction dropped or changed while stalled");

	// operand side may only stall when the result side is stalled
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("operand channel stalled without result backpressure");

	// a clamped result is an infinity pattern
	a_sat_is_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_bits[dus_pkg::MagW-1:0] == dus_pkg::InfMag)
		else $error("saturated result is not an infinity");

	// nothing leaves right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind double_ulp_step dus_checker u_dus_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (operand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_bits  (result.result_bits),
	.out_sat   (result.saturated)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for double_ulp_step
// Drives operand transactions with random gaps and result stalls, predicts
// each stepped binary64 pattern and its saturation flag, and compares every
// result transaction in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
	import dus_pkg::*;

	localparam logic [WordW-1:0] SignBit    = 64'h8000_0000_0000_0000;
	localparam logic [WordW-1:0] InfPattern = {1'b0, InfMag};
	localparam logic             DirUp      = 1'b0;
	localparam logic             DirDown    = 1'b1;
	localparam int unsigned      CycleLimit = 200000;
	localparam int unsigned      RandPerPhase = 400;

	class ulp_scoreboard;
		result_t     expected_q[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		// move a non-NaN pattern up by a nonzero count, sign-magnitude style
		function result_t move_up(logic [WordW-1:0] bits, logic [WordW-1:0] count);
			result_t          res;
			logic [WordW-1:0] mag;
			logic [WordW-1:0] rise;
			mag = {1'b0, bits[MagW-1:0]};
			res.saturated = 1'b0;
			if (!bits[WordW-1]) begin
				if (count < InfPattern - mag) begin
					res.result_bits = mag + count;
				end else begin
					res.result_bits = InfPattern;
					res.saturated   = 1'b1;
				end
			end else if (mag >= count) begin
				res.result_bits = SignBit | (mag - count);
			end else begin
				rise = count - mag;
				if (rise < InfPattern) begin
					res.result_bits = rise;
				end else begin
					res.result_bits = InfPattern;
					res.saturated   = 1'b1;
				end
			end
			return res;
		endfunction

		function result_t predict_step(item_t it);
			result_t res;
			if ({1'b0, it.value_bits[MagW-1:0]} > InfPattern || it.step_count == '0) begin
				res.result_bits = it.value_bits;
				res.saturated   = 1'b0;
			end else if (it.mode == DirDown) begin
				res = move_up(it.value_bits ^ SignBit, it.step_count);
				res.result_bits ^= SignBit;
			end else begin
				res = move_up(it.value_bits, it.step_count);
			end
			return res;
		endfunction

		function void note_operand(item_t it);
			expected_q.push_back(predict_step(it));
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: result_bits %h saturated %b",
					got.result_bits, got.saturated);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.result_bits !== exp_res.result_bits) begin
				$error("result_bits: expected %h, actual %h",
					exp_res.result_bits, got.result_bits);
				errors++;
			end
			if (got.saturated !== exp_res.saturated) begin
				$error("saturated: expected %b, actual %b",
					exp_res.saturated, got.saturated);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	ulp_scoreboard sb;

	dus_item_if   op_if ();
	dus_result_if res_if ();

	double_ulp_step dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (op_if),
		.result  (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// observe both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && op_if.valid && op_if.ready)
			sb.note_operand('{op_if.value_bits, op_if.step_count, op_if.mode});
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result('{res_if.result_bits, res_if.saturated});
	end

	always @(negedge clk) begin
		if (arst_n)
			res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		else
			res_if.ready <= 1'b0;
	end

	function automatic item_t make_item(logic [WordW-1:0] v, logic [WordW-1:0] n, logic d);
		item_t it;
		it.value_bits = v;
		it.step_count = n;
		it.mode       = d;
		return it;
	endfunction

	function automatic logic [WordW-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t rand_item();
		item_t            it;
		logic             sgn;
		logic [WordW-1:0] mag;
		sgn = 1'($urandom_range(1));
		case ($urandom_range(9))
			0, 1, 2, 3: it.value_bits = rand_word();
			4: it.value_bits = {sgn, 63'($urandom_range(1000))};
			5: it.value_bits = {sgn, InfMag - 63'($urandom_range(1000))};
			6: begin
				case ($urandom_range(2))
					0: it.value_bits = {sgn, 63'd0};
					1: it.value_bits = {sgn, InfMag};
					default: it.value_bits = {sgn, 11'h7ff, 52'(rand_word()) | 52'd1};
				endcase
			end
			default: it.value_bits = {sgn, 11'($urandom_range(11'h7fe)), 52'(rand_word())};
		endcase
		mag = {1'b0, it.value_bits[MagW-1:0]};
		case ($urandom_range(9))
			0: it.step_count = '0;
			1, 2, 3: it.step_count = 64'($urandom_range(1, 64));
			4: it.step_count = rand_word();
			5: it.step_count = (64'd1 << $urandom_range(63)) + 64'($urandom_range(3));
			// around the point where the move crosses zero
			6: it.step_count = mag + 64'($urandom_range(2)) - 64'd1;
			// around the point where the move reaches infinity
			7: begin
				if ($urandom_range(1))
					it.step_count = InfPattern - mag + 64'($urandom_range(2)) - 64'd1;
				else
					it.step_count = InfPattern + mag + 64'($urandom_range(2)) - 64'd1;
			end
			8: it.step_count = 64'($urandom);
			default: it.step_count = '1 - 64'($urandom_range(3));
		endcase
		it.mode = 1'($urandom_range(1));
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic drive_operand(item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			op_if.valid <= 1'b0;
			@(negedge clk);
		end
		op_if.valid      <= 1'b1;
		op_if.value_bits <= it.value_bits;
		op_if.step_count <= it.step_count;
		op_if.mode       <= it.mode;
		do @(posedge clk); while (!op_if.ready);
		@(negedge clk);
	endtask

	task automatic run_directed();
		drive_operand(make_item(64'h3ff0_0000_0000_0000, 64'd0, DirUp));
		drive_operand(make_item(64'h7ff8_0000_0000_0000, 64'd5, DirUp));
		drive_operand(make_item(64'hfff0_0000_0000_0001, 64'd1, DirDown));
		drive_operand(make_item('1, '1, DirUp));
		drive_operand(make_item(64'h0, 64'd1, DirUp));
		drive_operand(make_item(SignBit, 64'd1, DirUp));
		drive_operand(make_item(64'h0, 64'd1, DirDown));
		drive_operand(make_item(SignBit, 64'd1, DirDown));
		drive_operand(make_item(InfPattern, 64'd1, DirUp));
		drive_operand(make_item(SignBit | InfPattern, 64'd1, DirUp));
		drive_operand(make_item(InfPattern, 64'd1, DirDown));
		drive_operand(make_item(SignBit | InfPattern, 64'd3, DirDown));
		drive_operand(make_item(64'h7fef_ffff_ffff_ffff, 64'd1, DirUp));
		drive_operand(make_item(64'h7fef_ffff_ffff_fffe, 64'd1, DirUp));
		// negative magnitude used up exactly gives minus zero, one more crosses
		drive_operand(make_item(64'h8000_0000_0000_0005, 64'd5, DirUp));
		drive_operand(make_item(64'h8000_0000_0000_0005, 64'd6, DirUp));
		drive_operand(make_item(64'h0000_0000_0000_0005, 64'd5, DirDown));
		drive_operand(make_item(64'h3ff0_0000_0000_0000, '1, DirUp));
		drive_operand(make_item(64'hbff0_0000_0000_0000, '1, DirUp));
		drive_operand(make_item(64'h3ff0_0000_0000_0000, '1, DirDown));
		// crossing from the most negative finite right up to infinity
		drive_operand(make_item(64'hffef_ffff_ffff_ffff, 64'hffdf_ffff_ffff_ffff, DirUp));
		drive_operand(make_item(64'hffef_ffff_ffff_ffff, 64'hffdf_ffff_ffff_fffe, DirUp));
		drive_operand(make_item(64'h3ff0_0000_0000_0000, 64'd1, DirUp));
		drive_operand(make_item(64'h3ff0_0000_0000_0000, 64'd1, DirDown));
		drive_operand(make_item(64'h0, SignBit, DirDown));
	endtask

	initial begin
		sb            = new();
		cycle_count   = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		arst_n           = 1'b0;
		op_if.valid      = 1'b0;
		op_if.value_bits = '0;
		op_if.step_count = '0;
		op_if.mode       = DirUp;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
				default: begin src_idle_pct = 6; snk_stall_pct = 6; end
			endcase
			for (int i = 0; i < RandPerPhase; i++)
				drive_operand(rand_item());
		end
		op_if.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### double_ulp_step.f
hw/rtl/dus_pkg.sv
hw/rtl/dus_stream_if.sv
hw/rtl/dus_step.sv
hw/rtl/double_ulp_step.sv
hw/rtl/dus_checker.sv
verif/tb.sv
